// ----- rtl/imu_pkg.sv -----
// Shared types, constants and tables for the tilt complementary filter.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps
package imu_pkg;

  localparam int RotationSteps = 16;
  localparam int StepW = $clog2(RotationSteps + 1);
  localparam int AccW = 34;
  localparam int CordW = 40;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] REG_BLEND = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LEFT  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RIGHT = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_UP    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DOWN  = 3'd4;

  localparam logic signed [AccW-1:0] QuarterTurn = 34'sd5898240;
  localparam logic signed [15:0] HalfTurn64 = 16'sd11520;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] roll_out;
    logic signed [15:0] pitch_out;
    logic signed [15:0] yaw_out;
    logic flag_left;
    logic flag_right;
    logic flag_up;
    logic flag_down;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture input item, start square sum
    logic sqrt_init;  // start the root
    logic sqrt_step;  // one root bit
    logic cord_init;  // load CORDIC vector (sel chooses roll or pitch)
    logic cord_sel;   // 0 roll, 1 pitch
    logic cord_step;  // one CORDIC rotation
    logic cord_done;  // round the angle into roll or pitch
    logic gyro;       // scale the three rates
    logic blend_mul;  // filter products
    logic blend_fin;  // filter sum and saturation
    logic publish;    // write the result register
  } dp_cmd_t;

  function automatic logic signed [AccW-1:0] atan_entry(input logic [4:0] i);
    case (i)
      5'd0: atan_entry = 34'sd2949120;
      5'd1: atan_entry = 34'sd1740967;
      5'd2: atan_entry = 34'sd919879;
      5'd3: atan_entry = 34'sd466945;
      5'd4: atan_entry = 34'sd234379;
      5'd5: atan_entry = 34'sd117304;
      5'd6: atan_entry = 34'sd58666;
      5'd7: atan_entry = 34'sd29335;
      5'd8: atan_entry = 34'sd14668;
      5'd9: atan_entry = 34'sd7334;
      5'd10: atan_entry = 34'sd3667;
      5'd11: atan_entry = 34'sd1833;
      5'd12: atan_entry = 34'sd917;
      5'd13: atan_entry = 34'sd458;
      5'd14: atan_entry = 34'sd229;
      5'd15: atan_entry = 34'sd115;
      5'd16: atan_entry = 34'sd57;
      5'd17: atan_entry = 34'sd29;
      5'd18: atan_entry = 34'sd14;
      5'd19: atan_entry = 34'sd7;
      5'd20: atan_entry = 34'sd4;
      5'd21: atan_entry = 34'sd2;
      5'd22: atan_entry = 34'sd1;
      default: atan_entry = 34'sd0;
    endcase
  endfunction

endpackage

// ----- rtl/imu_in_if.sv -----
// Input channel: valid/ready with one sensor item.
// Depends on imu_pkg.
`timescale 1ns / 1ps
interface imu_in_if import imu_pkg::*; ();
  logic valid;
  logic ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/imu_out_if.sv -----
// Output channel: valid/ready with one filtered result.
// Depends on imu_pkg.
`timescale 1ns / 1ps
interface imu_out_if import imu_pkg::*; ();
  logic valid;
  logic ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/imu_ctrl.sv -----
// Sequencer for the tilt filter: issues datapath commands step by step.
// Depends on imu_pkg.
`timescale 1ns / 1ps
module imu_ctrl import imu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    res_busy,
  output dp_cmd_t cmd,
  output logic [StepW-1:0] step
);

  typedef enum logic [3:0] {
    IDLE, SQ, SQRT, ROLL_INIT, ROLL_RUN, ROLL_END, PITCH_INIT, PITCH_RUN,
    PITCH_END, GYRO, MUL, FIN, PUB
  } state_t;

  state_t state;
  logic [4:0] cnt;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd = '0;
    cmd.load = (state == IDLE) && in_valid;
    cmd.sqrt_init = (state == SQ);
    cmd.sqrt_step = (state == SQRT);
    cmd.cord_init = (state == ROLL_INIT) || (state == PITCH_INIT);
    cmd.cord_sel = (state == PITCH_INIT) || (state == PITCH_RUN) || (state == PITCH_END);
    cmd.cord_step = (state == ROLL_RUN) || (state == PITCH_RUN);
    cmd.cord_done = (state == ROLL_END) || (state == PITCH_END);
    cmd.gyro = (state == GYRO);
    cmd.blend_mul = (state == MUL);
    cmd.blend_fin = (state == FIN);
    cmd.publish = (state == PUB) && !res_busy;
  end

  assign step = cnt[StepW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt <= '0;
    end else begin
      case (state)
        IDLE: if (in_valid) state <= SQ;
        SQ: begin
          state <= SQRT;
          cnt <= '0;
        end
        // 24 root bits for a 48-bit radicand
        SQRT: begin
          if (cnt == 5'd23) state <= ROLL_INIT;
          cnt <= cnt + 5'd1;
        end
        ROLL_INIT: begin
          state <= ROLL_RUN;
          cnt <= '0;
        end
        ROLL_RUN: begin
          if (cnt == 5'(RotationSteps - 1)) state <= ROLL_END;
          cnt <= cnt + 5'd1;
        end
        ROLL_END: state <= PITCH_INIT;
        PITCH_INIT: begin
          state <= PITCH_RUN;
          cnt <= '0;
        end
        PITCH_RUN: begin
          if (cnt == 5'(RotationSteps - 1)) state <= PITCH_END;
          cnt <= cnt + 5'd1;
        end
        PITCH_END: state <= GYRO;
        GYRO: state <= MUL;
        MUL: state <= FIN;
        FIN: state <= PUB;
        PUB: if (!res_busy) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/imu_dp.sv -----
// Datapath: square sum, bit-serial root, shared CORDIC, gyro scaling, filter.
// Depends on imu_pkg; driven by imu_ctrl commands.
`timescale 1ns / 1ps
module imu_dp import imu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  dp_cmd_t cmd,
  input  logic [StepW-1:0] step,
  input  in_item_t item,
  input  logic [16:0] blend_weight,
  input  logic signed [8:0] left_limit,
  input  logic signed [8:0] right_limit,
  input  logic signed [8:0] up_limit,
  input  logic signed [8:0] down_limit,
  output out_item_t result
);

  in_item_t hold;
  logic [31:0] sq;
  logic [47:0] rad;   // remaining radicand
  logic [23:0] root;
  logic [25:0] rem;
  logic signed [CordW-1:0] cx, cy;
  logic signed [AccW-1:0] acc;
  logic zero_y, neg_x;
  logic signed [15:0] roll, pitch;
  logic signed [15:0] grx, gry, grz;
  logic signed [17:0] fr, fp, fy;
  logic signed [35:0] pr_a, pp_a, py_a, pr_b, pp_b, py_b;
  logic signed [15:0] last_roll, last_pitch, last_yaw;
  logic signed [17:0] wgt;

  // Root of sq*65536 taken two radicand bits a cycle (restoring form).
  logic [27:0] trial;
  logic [27:0] rem_sh;
  logic [1:0] pair;
  always_comb begin
    pair = rad[47:46];
    rem_sh = {rem, pair};
    trial = {2'b00, root, 2'b01};
  end

  // Gyro scale: q = (|raw|*128 + 131) / 262, by reciprocal.
  function automatic logic signed [15:0] gscale(input logic signed [15:0] raw);
    logic [16:0] mag;
    logic [23:0] num;
    logic [47:0] prod;
    logic [23:0] q;
    logic [33:0] chk;
    begin
      mag = raw[15] ? 17'(-{raw[15], raw}) : {1'b0, raw};
      num = 24'({mag, 7'd0}) + 24'd131;
      // 2^32/262 rounded up; error corrected by a compare in each direction
      prod = 48'(num) * 48'd16393005;
      q = 24'(prod >> 32);
      chk = 34'(q) * 34'd262;
      if (34'(num) >= chk + 34'd262) q = q + 24'd1;
      else if (34'(num) < chk) q = q - 24'd1;
      gscale = raw[15] ? -16'(q) : 16'(q);
    end
  endfunction

  function automatic logic signed [15:0] sat(input logic signed [37:0] s);
    logic signed [21:0] r;
    begin
      r = 22'((s + 38'sd32768) >>> 16);
      if (r > 22'sd32767) sat = 16'sh7FFF;
      else if (r < -22'sd32768) sat = 16'sh8000;
      else sat = r[15:0];
    end
  endfunction

  logic signed [CordW-1:0] dx, dy;
  logic [4:0] sidx;
  assign sidx = 5'(step);
  assign dx = cy >>> sidx;
  assign dy = cx >>> sidx;

  logic signed [CordW-1:0] ix, iy;
  always_comb begin
    if (cmd.cord_sel) begin
      ix = CordW'($signed({1'b0, root}));
      iy = -(CordW'(hold.accel_x) <<< 8);
    end else begin
      ix = CordW'(hold.accel_z) <<< 8;
      iy = CordW'(hold.accel_y) <<< 8;
    end
  end

  logic signed [AccW-1:0] accr;
  logic signed [15:0] ang;
  assign accr = (acc + 34'sd512) >>> 10;
  always_comb begin
    if (zero_y) ang = neg_x ? HalfTurn64 : 16'sd0;
    else ang = accr[15:0];
  end

  assign fr = 18'(grx) + 18'(roll);
  assign fp = 18'(gry) + 18'(pitch);
  assign fy = 18'(grz);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_roll <= '0;
      last_pitch <= '0;
      last_yaw <= '0;
    end else begin
      if (cmd.load) begin
        hold <= item;
        sq <= 32'($signed(item.accel_y) * $signed(item.accel_y))
            + 32'($signed(item.accel_z) * $signed(item.accel_z));
        wgt <= (blend_weight > 17'd65536) ? 18'sd65536 : $signed({1'b0, blend_weight});
      end
      if (cmd.sqrt_init) begin
        rad <= {sq, 16'd0};
        root <= '0;
        rem <= '0;
      end
      if (cmd.sqrt_step) begin
        rad <= {rad[45:0], 2'b00};
        if (rem_sh >= trial) begin
          rem <= 26'(rem_sh - trial);
          root <= {root[22:0], 1'b1};
        end else begin
          rem <= rem_sh[25:0];
          root <= {root[22:0], 1'b0};
        end
      end
      if (cmd.cord_init) begin
        zero_y <= (iy == '0);
        neg_x <= ix[CordW-1];
        if (ix[CordW-1]) begin
          if (!iy[CordW-1]) begin
            cx <= iy; cy <= -ix; acc <= QuarterTurn;
          end else begin
            cx <= -iy; cy <= ix; acc <= -QuarterTurn;
          end
        end else begin
          cx <= ix; cy <= iy; acc <= '0;
        end
      end
      if (cmd.cord_step) begin
        if (!cy[CordW-1]) begin
          cx <= cx + dx; cy <= cy - dy; acc <= acc + atan_entry(sidx);
        end else begin
          cx <= cx - dx; cy <= cy + dy; acc <= acc - atan_entry(sidx);
        end
      end
      if (cmd.cord_done) begin
        if (cmd.cord_sel) pitch <= ang;
        else roll <= ang;
      end
      if (cmd.gyro) begin
        grx <= gscale(hold.rate_x);
        gry <= gscale(hold.rate_y);
        grz <= gscale(hold.rate_z);
      end
      if (cmd.blend_mul) begin
        pr_a <= 36'(fr) * 36'(wgt);
        pp_a <= 36'(fp) * 36'(wgt);
        py_a <= 36'(fy) * 36'(wgt);
        pr_b <= 36'(last_roll) * 36'(18'sd65536 - wgt);
        pp_b <= 36'(last_pitch) * 36'(18'sd65536 - wgt);
        py_b <= 36'(last_yaw) * 36'(18'sd65536 - wgt);
      end
      if (cmd.blend_fin) begin
        last_roll <= sat(38'(pr_a) + 38'(pr_b));
        last_pitch <= sat(38'(pp_a) + 38'(pp_b));
        last_yaw <= sat(38'(py_a) + 38'(py_b));
      end
      if (cmd.publish) begin
        result.roll_out <= last_roll;
        result.pitch_out <= last_pitch;
        result.yaw_out <= last_yaw;
        result.flag_left <= 18'(last_roll) < (18'(left_limit) <<< 6);
        result.flag_right <= 18'(last_roll) > (18'(right_limit) <<< 6);
        result.flag_up <= 18'(last_pitch) > (18'(up_limit) <<< 6);
        result.flag_down <= 18'(last_pitch) < (18'(down_limit) <<< 6);
      end
    end
  end

endmodule

// ----- rtl/imu_tilt_complementary_filter.sv -----
// Each item passes the square sum, 24 root steps, two 16-step CORDIC passes (roll, then
// pitch), gyro scaling and the filter before the result is registered for output.
// No new item is taken while one is in process; the next is taken once the result is registered.
// The shared CORDIC unit and the bit-serial root take most of the processing of an item.
// Reset (rst, synchronous) clears the filter history and loads default registers.
// Depends on imu_pkg, imu_in_if, imu_out_if, imu_ctrl and imu_dp.
`timescale 1ns / 1ps
module imu_tilt_complementary_filter import imu_pkg::*; (
  input  logic clk,
  input  logic rst,
  imu_in_if.sink   in_ch,
  imu_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [16:0] blend_weight;
  logic signed [8:0] left_limit, right_limit, up_limit, down_limit;
  dp_cmd_t cmd;
  logic [StepW-1:0] step;
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight <= 17'd64225;
      left_limit <= -9'sd10;
      right_limit <= 9'sd10;
      up_limit <= 9'sd10;
      down_limit <= -9'sd10;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLEND: blend_weight <= cfg_data;
        REG_LEFT: left_limit <= cfg_data[8:0];
        REG_RIGHT: right_limit <= cfg_data[8:0];
        REG_UP: up_limit <= cfg_data[8:0];
        REG_DOWN: down_limit <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // A finished result waits in the output register until its transfer.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.publish) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end
  assign out_ch.valid = out_valid;

  imu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .res_busy(out_valid && !out_ch.ready), .cmd(cmd), .step(step)
  );

  imu_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .step(step), .item(in_ch.data),
    .blend_weight(blend_weight), .left_limit(left_limit),
    .right_limit(right_limit), .up_limit(up_limit), .down_limit(down_limit),
    .result(out_ch.data)
  );

endmodule

// ----- test/imu_tilt_complementary_filter_tb.sv -----
// Testbench for the tilt complementary filter: drives sensor items, predicts each
// filtered result in SystemVerilog and compares it field by field.
// Depends on imu_pkg, imu_in_if, imu_out_if and the imu_tilt_complementary_filter RTL.
`timescale 1ns / 1ps
module imu_tilt_complementary_filter_tb;
  import imu_pkg::*;

  localparam int SettleCycles = 100;
  localparam longint CycleLimit = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  imu_in_if in_ch ();
  imu_out_if out_ch ();

  imu_tilt_complementary_filter dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t sample_q[$];
  out_item_t result_q[$];
  int errors = 0;
  longint cycles = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_off = 0;

  // Predictor state and register copies.
  logic [16:0] weight;
  logic signed [8:0] lim_left, lim_right, lim_up, lim_down;
  longint hist_roll, hist_pitch, hist_yaw;

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root64(longint v);
    longint r, bit_v;
    r = 0;
    bit_v = 64'sd1 <<< 62;
    while (bit_v > v) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (v >= r + bit_v) begin
        v = v - (r + bit_v);
        r = (r >>> 1) + bit_v;
      end else begin
        r = r >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return r;
  endfunction

  function automatic longint tilt_angle(longint x, longint y);
    longint acc, t, dx, dy, step;
    acc = 0;
    if (y == 0) return (x < 0) ? 11520 : 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = 5898240;
      end else begin
        x = -y; y = t; acc = -5898240;
      end
    end
    for (int i = 0; i < RotationSteps && i < 24; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      step = atan_entry(i[4:0]);
      if (y >= 0) begin
        x += dx; y -= dy; acc += step;
      end else begin
        x -= dx; y += dy; acc -= step;
      end
    end
    return floor_sh(acc + 512, 10);
  endfunction

  function automatic longint rate_to_angle(longint raw);
    longint mag, q;
    mag = raw < 0 ? -raw : raw;
    q = (mag * 128 + 131) / 262;
    return raw < 0 ? -q : q;
  endfunction

  function automatic longint mix(longint fresh, longint last, longint a);
    longint s, r;
    s = a * fresh + (65536 - a) * last;
    r = floor_sh(s + 32768, 16);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic out_item_t filter_result(in_item_t it);
    longint ax, ay, az, a, m, roll, pitch;
    out_item_t o;
    ax = it.accel_x; ay = it.accel_y; az = it.accel_z;
    a = (weight > 17'd65536) ? 65536 : longint'(weight);
    m = root64((ay * ay + az * az) <<< 16);
    roll = tilt_angle(az * 256, ay * 256);
    pitch = tilt_angle(m, -ax * 256);
    hist_roll = mix(rate_to_angle(longint'(it.rate_x)) + roll, hist_roll, a);
    hist_pitch = mix(rate_to_angle(longint'(it.rate_y)) + pitch, hist_pitch, a);
    hist_yaw = mix(rate_to_angle(longint'(it.rate_z)), hist_yaw, a);
    o.roll_out = hist_roll[15:0];
    o.pitch_out = hist_pitch[15:0];
    o.yaw_out = hist_yaw[15:0];
    o.flag_left = hist_roll < longint'(lim_left) * 64;
    o.flag_right = hist_roll > longint'(lim_right) * 64;
    o.flag_up = hist_pitch > longint'(lim_up) * 64;
    o.flag_down = hist_pitch < longint'(lim_down) * 64;
    return o;
  endfunction

  // Driver: offers queued samples, predicting each one at its transfer.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) result_q.push_back(filter_result(in_ch.data));
      if (sample_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= sample_q.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure plus an optional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $error("result with no expectation: %p", out_ch.data);
          errors++;
        end else begin
          out_item_t e;
          e = result_q.pop_front();
          if (out_ch.data.roll_out !== e.roll_out) begin
            $error("roll_out expected %0d actual %0d", e.roll_out, out_ch.data.roll_out);
            errors++;
          end
          if (out_ch.data.pitch_out !== e.pitch_out) begin
            $error("pitch_out expected %0d actual %0d", e.pitch_out, out_ch.data.pitch_out);
            errors++;
          end
          if (out_ch.data.yaw_out !== e.yaw_out) begin
            $error("yaw_out expected %0d actual %0d", e.yaw_out, out_ch.data.yaw_out);
            errors++;
          end
          if (out_ch.data.flag_left !== e.flag_left) begin
            $error("flag_left expected %0b actual %0b", e.flag_left, out_ch.data.flag_left);
            errors++;
          end
          if (out_ch.data.flag_right !== e.flag_right) begin
            $error("flag_right expected %0b actual %0b", e.flag_right,
                   out_ch.data.flag_right);
            errors++;
          end
          if (out_ch.data.flag_up !== e.flag_up) begin
            $error("flag_up expected %0b actual %0b", e.flag_up, out_ch.data.flag_up);
            errors++;
          end
          if (out_ch.data.flag_down !== e.flag_down) begin
            $error("flag_down expected %0b actual %0b", e.flag_down, out_ch.data.flag_down);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("imu_tilt_complementary_filter_tb failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  task automatic add_sample(int ax, int ay, int az, int gx, int gy, int gz);
    in_item_t it;
    it.accel_x = ax[15:0]; it.accel_y = ay[15:0]; it.accel_z = az[15:0];
    it.rate_x = gx[15:0]; it.rate_y = gy[15:0]; it.rate_z = gz[15:0];
    sample_q.push_back(it);
  endtask

  task automatic add_random(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(9);
      if (r < 2)
        add_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (r < 3)
        // Vectors in the x-z plane, often lying on an axis.
        add_sample(($urandom_range(1)) ? 0 : $urandom, 0,
                   ($urandom_range(1)) ? 0 : $urandom, $urandom_range(400) - 200,
                   $urandom_range(400) - 200, $urandom);
      else
        // Sensor-like samples within about one g per axis with modest rates.
        add_sample($urandom_range(32000) - 16000, $urandom_range(32000) - 16000,
                   $urandom_range(32000) - 16000, $urandom_range(6000) - 3000,
                   $urandom_range(6000) - 3000, $urandom_range(6000) - 3000);
    end
  endtask

  // Checks run just after the edge so the driver's updates are already visible.
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (sample_q.size() > 0 || in_ch.valid || result_q.size() > 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_reg(logic [CfgIdxW-1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CfgDataW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BLEND: weight = val[16:0];
      REG_LEFT: lim_left = val[8:0];
      REG_RIGHT: lim_right = val[8:0];
      REG_UP: lim_up = val[8:0];
      REG_DOWN: lim_down = val[8:0];
      default: ;
    endcase
  endtask

  initial begin
    weight = 17'd64225;
    lim_left = -9'sd10; lim_right = 9'sd10; lim_up = 9'sd10; lim_down = -9'sd10;
    hist_roll = 0; hist_pitch = 0; hist_yaw = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, zero vector, vectors on the axes.
    src_idle_pct = 16; snk_idle_pct = 72;
    add_sample(0, 0, 0, 0, 0, 0);
    add_sample(0, 0, 16384, 0, 0, 0);
    add_sample(0, 0, -16384, 0, 0, 0);
    add_sample(0, 16384, 0, 0, 0, 0);
    add_sample(0, -16384, 0, 0, 0, 0);
    add_sample(16384, 0, 0, 0, 0, 0);
    add_sample(-16384, 0, 0, 0, 0, 0);
    add_sample(-32768, -32768, -32768, -32768, -32768, -32768);
    add_sample(32767, 32767, 32767, 32767, 32767, 32767);
    add_sample(-32768, 32767, -32768, 32767, -32768, 32767);
    add_sample(32767, -32768, 32767, -32768, 32767, -32768);
    add_sample(1, -1, -1, 131, -131, 1);
    add_sample(-1, 1, -32768, -1, 1, 65);
    drain();

    // Long receiver hold-off so the block fills up and stalls its input.
    hold_off = 300;
    add_random(20);
    drain();

    add_random(120);
    drain();

    set_reg(REG_BLEND, 65536);
    set_reg(REG_LEFT, -180);
    set_reg(REG_RIGHT, 180);
    set_reg(REG_UP, -180);
    set_reg(REG_DOWN, 180);
    set_reg(3'd7, 5);
    src_idle_pct = 72; snk_idle_pct = 16;
    add_random(80);
    drain();

    set_reg(REG_BLEND, 0);
    set_reg(REG_LEFT, 255);
    set_reg(REG_RIGHT, -256);
    set_reg(REG_UP, 0);
    set_reg(REG_DOWN, 0);
    add_random(20);
    drain();

    set_reg(REG_BLEND, 131071);
    add_random(20);
    drain();

    set_reg(REG_BLEND, 32768);
    set_reg(REG_LEFT, -5);
    set_reg(REG_RIGHT, 5);
    set_reg(REG_UP, 30);
    set_reg(REG_DOWN, -30);
    src_idle_pct = 0; snk_idle_pct = 0;
    add_random(140);
    drain();

    if (errors == 0 && result_q.size() == 0) begin
      $display("imu_tilt_complementary_filter_tb passed");
    end else begin
      $display("imu_tilt_complementary_filter_tb failed");
    end
    $finish;
  end
endmodule
